FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rptw_pkg.sv
// ---------------------------------------------------------------------------
// rptw_pkg
// Constants and types of the radix page table walker.
// ---------------------------------------------------------------------------
`default_nettype none

package rptw_pkg;

    // Port field widths
    localparam int VFN_W    = 32;
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int CFG_W    = 6;

    // Table geometry
    localparam int UPPER_BITS = 12;
    localparam int LEAF_BITS  = 8;
    localparam int TOTAL_BITS = 2 * UPPER_BITS + LEAF_BITS;
    localparam int SPAN_BITS  = (UPPER_BITS > LEAF_BITS) ? UPPER_BITS : LEAF_BITS;
    localparam int LW_W       = $clog2(SPAN_BITS + 1);
    localparam int LVL_W      = 2;

    localparam int NODE_POOL  = 16;
    localparam int NODE_W     = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int NODE_CNT_W = $clog2(NODE_POOL + 1);

    localparam int ENTRY_POOL  = 65536;
    localparam int ENTRY_LIMIT = (ENTRY_POOL < 65536) ? ENTRY_POOL : 65536;
    localparam int ENTRY_CNT_W = $clog2(ENTRY_LIMIT + 1);

    localparam int PTR_W      = HANDLE_W;
    localparam int ADDR_W     = NODE_W + SPAN_BITS;
    localparam int SLOT_COUNT = NODE_POOL * (2 ** SPAN_BITS);
    localparam int CLR_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(20);

    typedef struct packed {
        logic             valid;
        logic [PTR_W-1:0] ptr;
    } slot_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        slot_word_t        data;
    } slot_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/rptw_slot_mem.sv
// ---------------------------------------------------------------------------
// rptw_slot_mem
// Slot store of all table nodes: valid bit and pointer per slot, one write
// and one registered read per cycle; a clearing sweep drops writes.
// ---------------------------------------------------------------------------
`default_nettype none

module rptw_slot_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr_start,
    output logic                      clr_busy,
    input  rptw_pkg::slot_wr_t        wr,
    input  logic [rptw_pkg::ADDR_W-1:0] rd_addr,
    output rptw_pkg::slot_word_t      rd_data
);
    import rptw_pkg::*;

    slot_word_t       mem [SLOT_COUNT];
    slot_word_t       rd_data_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [CLR_W-1:0] clr_cnt_next;

    assign clr_busy = (clr_cnt_reg != CLR_W'(SLOT_COUNT));
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        if (clr_start)
        begin
            clr_cnt_next = '0;
        end
        else if (clr_busy)
        begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
        end
        else
        begin
            clr_cnt_next = clr_cnt_reg;
        end
    end

    // sweep restarts after reset and on every table flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            mem[clr_cnt_reg[ADDR_W-1:0]] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/radix_page_table_walk_allocate_top.sv
// ---------------------------------------------------------------------------
// radix_page_table_walk_allocate_top
// Radix page table walker that allocates missing nodes and leaf entries.
// ---------------------------------------------------------------------------
// One lookup at a time. After a transfer on the input channel the walk issues
// the root read, evaluates each table level in turn (1 to 3, set by the
// configured width) in the shared index unit, and loads the result register
// once it is free; only then is a new item taken. The slot store has one read
// and one write port; each level's read data arrives in the cycle after its
// address is issued.
// After reset and after every width write on cfg_wr_en the slot store is
// cleared one slot per cycle, all 65536 slots, with in_ready low; the flush
// also returns the node and entry pools to their reset state.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_page_table_walk_allocate_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rptw_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rptw_pkg::VFN_W-1:0]    vfn,
    input  logic [rptw_pkg::KIND_W-1:0]   ref_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rptw_pkg::HANDLE_W-1:0] entry_handle,
    output logic                          first_access,
    output logic [rptw_pkg::KIND_W-1:0]   kind_echo,
    output logic                          pool_exhausted
);
    import rptw_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]       cfg_width_reg;
    logic [NODE_CNT_W-1:0]  nodes_used_reg;
    logic [NODE_CNT_W-1:0]  nodes_used_next;
    logic [ENTRY_CNT_W-1:0] entries_used_reg;
    logic [ENTRY_CNT_W-1:0] entries_used_next;

    // lookup context
    logic [VFN_W-1:0]    v_reg;
    logic [VFN_W-1:0]    v_next;
    logic [CFG_W-1:0]    w_reg;
    logic [CFG_W-1:0]    w_next;
    logic [LVL_W-1:0]    nlev_reg;
    logic [LVL_W-1:0]    nlev_next;
    logic [LW_W-1:0]     lw_last_reg;
    logic [LW_W-1:0]     lw_last_next;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LVL_W-1:0]    lvl_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [KIND_W-1:0]   kind_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic                first_reg;
    logic                first_next;
    logic                exh_reg;
    logic                exh_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_first_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic                out_exh_reg;

    // plan for the incoming item
    logic [CFG_W-1:0]  w_eff;
    logic [VFN_W:0]    v_fill;
    logic [LVL_W-1:0]  nlev_plan;
    logic [LW_W-1:0]   lw_last_plan;

    // shared index unit
    logic [LVL_W-1:0]     lvl_sel;
    logic                 sel_last;
    logic [CFG_W-1:0]     shift_amt;
    logic [LW_W-1:0]      lw_sel;
    logic [VFN_W-1:0]     v_shifted;
    logic [SPAN_BITS:0]   lw_fill;
    logic [SPAN_BITS-1:0] idx;

    // level evaluation
    logic              cur_last;
    logic              hit;
    logic              node_full;
    logic              entry_full;
    logic              fail;
    logic              alloc;
    logic [NODE_W-1:0] child;
    logic              accept;
    logic              res_free;

    slot_wr_t          slot_wr;
    logic [ADDR_W-1:0] rd_addr;
    slot_word_t        rd_data;
    logic              clr_busy;

    rptw_slot_mem u_slot_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_start (cfg_wr_en),
        .clr_busy  (clr_busy),
        .wr        (slot_wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // --- level plan ---------------------------------------------------------
    always_comb
    begin
        w_eff  = (cfg_width_reg > CFG_W'(TOTAL_BITS)) ? CFG_W'(TOTAL_BITS) : cfg_width_reg;
        v_fill = {(VFN_W+1){1'b1}} << w_eff;
        if (w_eff <= CFG_W'(UPPER_BITS))
        begin
            nlev_plan    = LVL_W'(1);
            lw_last_plan = LW_W'(w_eff);
        end
        else if (w_eff <= CFG_W'(2 * UPPER_BITS))
        begin
            nlev_plan    = LVL_W'(2);
            lw_last_plan = LW_W'(w_eff - CFG_W'(UPPER_BITS));
        end
        else
        begin
            nlev_plan    = LVL_W'(3);
            lw_last_plan = LW_W'(w_eff - CFG_W'(2 * UPPER_BITS));
        end
    end

    // --- shared index unit: slot index of level lvl_sel ---------------------
    always_comb
    begin
        lvl_sel  = (state_reg == ST_LOOK) ? lvl_reg + LVL_W'(1) : lvl_reg;
        sel_last = (lvl_sel == nlev_reg - LVL_W'(1));
        if (sel_last)
        begin
            shift_amt = '0;
            lw_sel    = lw_last_reg;
        end
        else
        begin
            // upper levels are full width; last level sits at bit 0
            shift_amt = (lvl_sel == '0) ? w_reg - CFG_W'(UPPER_BITS)
                                        : w_reg - CFG_W'(2 * UPPER_BITS);
            lw_sel    = LW_W'(UPPER_BITS);
        end
        v_shifted = v_reg >> shift_amt;
        lw_fill   = {(SPAN_BITS+1){1'b1}} << lw_sel;
        idx       = v_shifted[SPAN_BITS-1:0] & ~lw_fill[SPAN_BITS-1:0];
    end

    // --- level evaluation ---------------------------------------------------
    always_comb
    begin
        cur_last   = (lvl_reg == nlev_reg - LVL_W'(1));
        hit        = rd_data.valid;
        node_full  = (nodes_used_reg >= NODE_CNT_W'(NODE_POOL));
        entry_full = (entries_used_reg >= ENTRY_CNT_W'(ENTRY_LIMIT));
        fail       = (state_reg == ST_LOOK) && !hit && (cur_last ? entry_full : node_full);
        alloc      = (state_reg == ST_LOOK) && !hit && !fail;
        child      = hit ? rd_data.ptr[NODE_W-1:0] : nodes_used_reg[NODE_W-1:0];
        res_free   = !out_valid_reg || out_ready;
        accept     = in_valid && in_ready;
    end

    // --- next state ---------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (cur_last || fail)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // --- outputs of the sequencer -------------------------------------------
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE) && !clr_busy;
        slot_wr.en    = alloc;
        slot_wr.addr  = addr_reg;
        slot_wr.data.valid = 1'b1;
        slot_wr.data.ptr   = cur_last ? entries_used_reg[PTR_W-1:0]
                                      : PTR_W'(nodes_used_reg);
        if (state_reg == ST_LOOK)
        begin
            rd_addr = {child, idx};
        end
        else
        begin
            rd_addr = {NODE_W'(0), idx};
        end
    end

    // --- datapath next values -----------------------------------------------
    always_comb
    begin
        v_next            = v_reg;
        w_next            = w_reg;
        nlev_next         = nlev_reg;
        lw_last_next      = lw_last_reg;
        lvl_next          = lvl_reg;
        addr_next         = addr_reg;
        kind_next         = kind_reg;
        handle_next       = handle_reg;
        first_next        = first_reg;
        exh_next          = exh_reg;
        nodes_used_next   = nodes_used_reg;
        entries_used_next = entries_used_reg;

        if (accept)
        begin
            v_next       = vfn & ~v_fill[VFN_W-1:0];
            w_next       = w_eff;
            nlev_next    = nlev_plan;
            lw_last_next = lw_last_plan;
            lvl_next     = '0;
            kind_next    = ref_kind;
        end

        if (state_reg == ST_READ)
        begin
            addr_next = rd_addr;
        end

        if (state_reg == ST_LOOK)
        begin
            if (fail)
            begin
                handle_next = '0;
                first_next  = 1'b0;
                exh_next    = 1'b1;
            end
            else if (cur_last)
            begin
                handle_next = hit ? rd_data.ptr : entries_used_reg[HANDLE_W-1:0];
                first_next  = !hit;
                exh_next    = 1'b0;
            end
            else
            begin
                lvl_next  = lvl_reg + LVL_W'(1);
                addr_next = rd_addr;
            end
        end

        if (alloc)
        begin
            if (cur_last)
            begin
                entries_used_next = entries_used_reg + ENTRY_CNT_W'(1);
            end
            else
            begin
                nodes_used_next = nodes_used_reg + NODE_CNT_W'(1);
            end
        end

        // flush resets both pools; only the root node stays allocated
        if (cfg_wr_en)
        begin
            nodes_used_next   = NODE_CNT_W'(1);
            entries_used_next = '0;
        end
    end

    always_comb
    begin
        if ((state_reg == ST_DONE) && res_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // --- control registers --------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cfg_width_reg    <= CFG_RESET;
            nodes_used_reg   <= NODE_CNT_W'(1);
            entries_used_reg <= '0;
            out_valid_reg    <= 1'b0;
            lvl_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_wr_en)
            begin
                cfg_width_reg <= cfg_wr_data;
            end
            nodes_used_reg   <= nodes_used_next;
            entries_used_reg <= entries_used_next;
            out_valid_reg    <= out_valid_next;
            lvl_reg          <= lvl_next;
        end
    end

    // --- payload registers --------------------------------------------------
    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        w_reg       <= w_next;
        nlev_reg    <= nlev_next;
        lw_last_reg <= lw_last_next;
        addr_reg    <= addr_next;
        kind_reg    <= kind_next;
        handle_reg  <= handle_next;
        first_reg   <= first_next;
        exh_reg     <= exh_next;
        if ((state_reg == ST_DONE) && res_free)
        begin
            out_handle_reg <= handle_reg;
            out_first_reg  <= first_reg;
            out_kind_reg   <= kind_reg;
            out_exh_reg    <= exh_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_handle   = out_handle_reg;
    assign first_access   = out_first_reg;
    assign kind_echo      = out_kind_reg;
    assign pool_exhausted = out_exh_reg;

endmodule

`default_nettype wire

FILE: rtl/rptw_checker.sv
// ---------------------------------------------------------------------------
// rptw_checker
// Port-level checks of the page table walker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rptw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_wr_en,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rptw_pkg::HANDLE_W-1:0] entry_handle,
    input logic                          first_access,
    input logic                          pool_exhausted
);
    import rptw_pkg::*;

    // a stalled result keeps its contents
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(entry_handle) && $stable(first_access) && $stable(pool_exhausted), "result changed while stalled")

    // failed allocation reports a null handle and no first access
    `ASSERT_CLK(a_exh_clean, out_valid && pool_exhausted |-> entry_handle == '0 && !first_access, "exhausted result carries a handle")

    // one lookup at a time
    `ASSERT_CLK(a_one_item, in_valid && in_ready |=> !in_ready, "input taken during a walk")

    // a width write flushes the table before the next lookup
    `ASSERT_CLK(a_flush_block, cfg_wr_en |=> !in_ready, "input taken right after a flush")

endmodule

bind radix_page_table_walk_allocate_top rptw_checker u_rptw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .entry_handle   (entry_handle),
    .first_access   (first_access),
    .pool_exhausted (pool_exhausted)
);

`default_nettype wire

FILE: bench/radix_page_table_walk_allocate_top_tb.sv
// ---------------------------------------------------------------------------
// radix_page_table_walk_allocate_top_tb
// Self-checking bench for the radix page table walker. A directed table
// exercises extremes and node pool exhaustion. Random lookups then run at
// several table widths, including zero and saturated widths. Every result
// is compared with a local walk of a shadow table or a typed row's result.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_page_table_walk_allocate_top_tb;

    import rptw_pkg::*;

    localparam int SPAN        = 1 << SPAN_BITS;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_ITEMS  = 248;
    localparam int REGIONS     = 20;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                first;
        logic [KIND_W-1:0]   kind;
        logic                exh;
    } walk_result_t;

    typedef struct {
        logic [VFN_W-1:0]  page;
        logic [KIND_W-1:0] kind;
        bit                typed;
        walk_result_t      res;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [VFN_W-1:0]    vfn;
    logic [KIND_W-1:0]   ref_kind;
    logic                out_valid;
    logic                out_ready;
    logic [HANDLE_W-1:0] entry_handle;
    logic                first_access;
    logic [KIND_W-1:0]   kind_echo;
    logic                pool_exhausted;

    // side info travelling with the payload: typed expectation for the row
    bit                  cur_typed;
    walk_result_t        cur_res;

    // shadow table
    bit                  slot_used [SLOT_COUNT];
    logic [PTR_W-1:0]    slot_link [SLOT_COUNT];
    int                  node_count;
    int                  entry_count;
    int                  width_reg;

    walk_result_t        lookup_q [$];
    logic [VFN_W-1:0]    page_history [$];
    logic [VFN_W-1:0]    region_base [REGIONS];
    stim_row_t           dir_rows [$];
    int                  phase_widths [7] = '{1, 0, 63, 32, 12, 24, 13};

    int                  fail_count;
    int                  items_taken;
    int                  results_seen;
    int                  first_seen;
    int                  exh_seen;
    int                  cycle_count;
    bit                  no_idle;
    bit                  hold_req;

    radix_page_table_walk_allocate_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .vfn            (vfn),
        .ref_kind       (ref_kind),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_handle   (entry_handle),
        .first_access   (first_access),
        .kind_echo      (kind_echo),
        .pool_exhausted (pool_exhausted)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int level_count(input int w);
        if (w <= UPPER_BITS)
            return 1;
        if (w <= 2 * UPPER_BITS)
            return 2;
        return 3;
    endfunction

    // last needed level is cut so the widths add up to w
    function automatic int level_width(input int w, input int l);
        int full;
        int rest;
        full = (l == 2) ? LEAF_BITS : UPPER_BITS;
        rest = w - l * UPPER_BITS;
        return (rest < full) ? rest : full;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_used[i] = 1'b0;
        node_count  = 1;
        entry_count = 0;
    endfunction

    function automatic walk_result_t walk_table(input logic [VFN_W-1:0] page,
                                                input logic [KIND_W-1:0] kind);
        int           w;
        int           nlev;
        int           consumed;
        int           lw;
        int           shift;
        int           node;
        int           addr;
        int           l;
        logic [63:0]  v;
        logic [63:0]  idx;
        walk_result_t r;
        w        = (width_reg > TOTAL_BITS) ? TOTAL_BITS : width_reg;
        v        = {32'd0, page} & ((64'd1 << w) - 64'd1);
        nlev     = level_count(w);
        consumed = 0;
        node     = 0;
        r        = '0;
        r.kind   = kind;
        for (l = 0; l < nlev; l++)
        begin
            lw    = level_width(w, l);
            shift = w - consumed - lw;
            idx   = (v >> shift) & ((64'd1 << lw) - 64'd1);
            consumed += lw;
            addr  = (node % NODE_POOL) * SPAN + int'(idx & 64'(SPAN - 1));
            if (l == nlev - 1)
            begin
                if (!slot_used[addr])
                begin
                    if (entry_count >= ENTRY_LIMIT)
                    begin
                        r.exh = 1'b1;
                        break;
                    end
                    slot_link[addr] = PTR_W'(entry_count);
                    slot_used[addr] = 1'b1;
                    entry_count++;
                    r.first = 1'b1;
                end
                r.handle = slot_link[addr];
            end
            else
            begin
                if (!slot_used[addr])
                begin
                    // nodes taken earlier in this walk stay allocated
                    if (node_count >= NODE_POOL)
                    begin
                        r.exh = 1'b1;
                        break;
                    end
                    slot_link[addr] = PTR_W'(node_count);
                    slot_used[addr] = 1'b1;
                    node_count++;
                end
                node = int'(slot_link[addr]);
            end
        end
        if (r.exh)
        begin
            r.handle = '0;
            r.first  = 1'b0;
        end
        return r;
    endfunction

    // mostly revisits and clustered pages so walks go deep; rest is noise
    function automatic logic [VFN_W-1:0] pick_page(input int w);
        int          ew;
        int          lw;
        int          sel;
        logic [63:0] mask;
        logic [63:0] leaf;
        logic [63:0] p;
        ew   = (w > TOTAL_BITS) ? TOTAL_BITS : w;
        lw   = level_width(ew, level_count(ew) - 1);
        mask = (64'd1 << ew) - 64'd1;
        leaf = (64'd1 << lw) - 64'd1;
        sel  = $urandom_range(0, 99);
        if (sel < 35 && page_history.size() > 0)
            p = {32'd0, page_history[$urandom_range(0, page_history.size() - 1)]};
        else if (sel < 85)
            p = ({32'd0, region_base[$urandom_range(0, REGIONS - 1)]} & ~leaf)
                | ({32'd0, $urandom} & leaf);
        else
            p = {32'd0, $urandom};
        // bits above the width are don't-care, keep them moving
        p = (p & mask) | ({32'd0, $urandom} & ~mask);
        page_history.push_back(p[31:0]);
        if (page_history.size() > 64)
            void'(page_history.pop_front());
        return p[31:0];
    endfunction

    // scoreboard: results first, then new transfers, then register writes
    always @(posedge clk)
    begin
        walk_result_t want;
        walk_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (first_access)
                    first_seen++;
                if (pool_exhausted)
                    exh_seen++;
                if (lookup_q.size() == 0)
                begin
                    $error("result with nothing pending: entry_handle %0d", entry_handle);
                    fail_count++;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    got  = '{entry_handle, first_access, kind_echo, pool_exhausted};
                    if (got.handle !== want.handle)
                    begin
                        $error("entry_handle: expected %0d, got %0d", want.handle, got.handle);
                        fail_count++;
                    end
                    if (got.first !== want.first)
                    begin
                        $error("first_access: expected %0d, got %0d", want.first, got.first);
                        fail_count++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $error("kind_echo: expected %0d, got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.exh !== want.exh)
                    begin
                        $error("pool_exhausted: expected %0d, got %0d", want.exh, got.exh);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = walk_table(vfn, ref_kind);
                if (cur_typed)
                    want = cur_res;
                lookup_q.push_back(want);
                items_taken++;
            end
            if (cfg_wr_en)
            begin
                width_reg = int'(cfg_wr_data);
                clear_table();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 23);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [VFN_W-1:0] page, input logic [KIND_W-1:0] kind,
                             input bit typed, input walk_result_t res);
        while (!no_idle && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        vfn       <= page;
        ref_kind  <= kind;
        cur_typed <= typed;
        cur_res   <= res;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (lookup_q.size() != 0)
            @(negedge clk);
        for (int n = 0; n < SETTLE_CYC; n++)
            @(negedge clk);
    endtask

    task automatic write_width(input int w);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(w);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random(input int w, input int count, input int hold_at,
                               input int pause_at);
        walk_result_t none;
        none = '0;
        for (int r = 0; r < REGIONS; r++)
            region_base[r] = $urandom;
        page_history.delete();
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                hold_req = 1'b1;
            if (k == pause_at)
                settle();
            send_item(pick_page(w), KIND_W'($urandom_range(0, 3)), 1'b0, none);
        end
    endtask

    function automatic stim_row_t mk_row(input logic [VFN_W-1:0] page,
                                         input logic [KIND_W-1:0] kind, input bit typed,
                                         input logic [HANDLE_W-1:0] h, input logic f,
                                         input logic e);
        stim_row_t row;
        row.page  = page;
        row.kind  = kind;
        row.typed = typed;
        row.res   = '{h, f, kind, e};
        return row;
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        vfn         = '0;
        ref_kind    = '0;
        cur_typed   = 1'b0;
        cur_res     = '0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        width_reg   = int'(CFG_RESET);
        clear_table();

        // reset width is 20: levels of 12 and 8 bits
        dir_rows.push_back(mk_row(32'h0000_0000, 2'd0, 1'b1, 16'd0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(32'hFFFF_FFFF, 2'd3, 1'b1, 16'd1, 1'b1, 1'b0));
        // high bits ignored: same pages as above
        dir_rows.push_back(mk_row(32'hFFF0_0000, 2'd1, 1'b1, 16'd0, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(32'h000F_FFFF, 2'd2, 1'b1, 16'd1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(32'h0000_0001, 2'd0, 1'b1, 16'd2, 1'b1, 1'b0));
        // fill the node pool: 13 new top-level slots
        for (int i = 1; i <= 13; i++)
            dir_rows.push_back(mk_row(VFN_W'((i << 8) | i), KIND_W'(i % 4), 1'b0,
                                      16'd0, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(32'h0000_0E00, 2'd3, 1'b1, 16'd0, 1'b0, 1'b1));
        dir_rows.push_back(mk_row(32'h0000_0D0D, 2'd1, 1'b0, 16'd0, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(32'h000F_FF7F, 2'd2, 1'b0, 16'd0, 1'b0, 1'b0));

        for (int n = 0; n < 5; n++)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].page, dir_rows[i].kind, dir_rows[i].typed,
                      dir_rows[i].res);
        send_random(int'(CFG_RESET), RAND_ITEMS - 20, -1, -1);

        foreach (phase_widths[p])
        begin
            settle();
            write_width(phase_widths[p]);
            no_idle = (phase_widths[p] == 24);
            send_random(phase_widths[p], RAND_ITEMS,
                        (phase_widths[p] == 32) ? 80 : -1,
                        (phase_widths[p] == 12) ? 120 : -1);
            no_idle = 1'b0;
        end

        settle();
        for (int n = 0; n < 16; n++)
            @(negedge clk);

        $display("covered %0d lookups at %0d table widths, %0d results checked",
                 items_taken, $size(phase_widths) + 1, results_seen);
        $display("%0d first accesses, %0d exhausted pools, %0d mismatches",
                 first_seen, exh_seen, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/rptw_pkg.sv
rtl/rptw_slot_mem.sv
rtl/radix_page_table_walk_allocate_top.sv
rtl/rptw_checker.sv
bench/radix_page_table_walk_allocate_top_tb.sv
